// ----- rtl/tbml_pkg.sv -----
// Shared types, widths and codes of the time bucket min/max logger.
package tbml_pkg;

  // Input field widths
  localparam int YearW   = 8;
  localparam int DayW    = 9;
  localparam int HourW   = 5;
  localparam int MinuteW = 6;
  localparam int PressW  = 20;
  localparam int ReadW   = 12;

  // Result field widths
  localparam int SlotW     = 4;
  localparam int BucketW   = 11;
  localparam int ChanW     = 3;
  localparam int ValueW    = 16;
  localparam int ReadOutW  = 8;
  localparam int FracBits  = 4;

  // Channel counts
  localparam int NumCh   = 5;
  localparam int NumRead = 4;

  // Stream and register port widths
  localparam int InDataW  = 96;
  localparam int OutDataW = 64;
  localparam int ApbDataW = 32;
  localparam int ApbAddrW = 3;

  localparam int SlotsDefault = 16;
  localparam int MinPerHour   = 60;
  localparam logic [BucketW-1:0] BucketReset = BucketW'(180);

  // Register word index (paddr[2])
  localparam logic RegBucketMin = 1'b0;

  typedef enum logic [ChanW-1:0] {
    ChPressure = 3'd0,
    ChOutTemp  = 3'd1,
    ChInTemp   = 3'd2,
    ChOutHum   = 3'd3,
    ChInHum    = 3'd4
  } channel_e;

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StDecide
  } state_e;

  // Lane control from the sequencer
  typedef struct packed {
    logic absorb;   // fold the current reading into the extremes
    logic restart;  // start the extremes over before folding
  } lane_ctrl_t;

  // Completed record handed to the result stage
  typedef struct packed {
    logic [SlotW-1:0]               slot;
    logic [YearW-1:0]               year;
    logic [DayW-1:0]                day;
    logic [BucketW-1:0]             bucket;
    logic [NumCh-1:0][ValueW-1:0]   hi;
    logic [NumCh-1:0][ValueW-1:0]   lo;
  } rec_t;

endpackage

// ----- rtl/tbml_div.sv -----
// Radix-2 restoring divider for the bucket number.
module tbml_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [tbml_pkg::BucketW-1:0] dividend_i,
  input  logic [tbml_pkg::BucketW-1:0] divisor_i,
  output logic                         done_o,
  output logic [tbml_pkg::BucketW-1:0] quotient_o
);

  localparam int W    = tbml_pkg::BucketW;
  localparam int CntW = $clog2(W + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            done_q, done_d;
  logic [W-1:0]    rem_q, rem_d;
  logic [W-1:0]    quo_q, quo_d;
  logic [W-1:0]    div_q;
  logic [W:0]      shifted;
  logic [W:0]      diff;
  logic            fits;

  // One quotient bit per step
  always_comb begin
    shifted = {rem_q, quo_q[W-1]};
    diff    = shifted - {1'b0, div_q};
    fits    = shifted >= {1'b0, div_q};
    rem_d   = fits ? diff[W-1:0] : shifted[W-1:0];
    quo_d   = {quo_q[W-2:0], fits};
    cnt_d   = cnt_q - CntW'(1);
    done_d  = (cnt_q == CntW'(1)) && !start_i;
  end

  // Step counter and done flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
      if (start_i) begin
        cnt_q <= CntW'(W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_d;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- rtl/tbml_lane.sv -----
// One channel lane: round, saturate and track minimum and maximum.
module tbml_lane #(
  parameter int IN_W  = tbml_pkg::ReadW,
  parameter int OUT_W = tbml_pkg::ReadOutW
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tbml_pkg::lane_ctrl_t   ctrl_i,
  input  logic signed [IN_W-1:0] value_i,
  output logic [OUT_W-1:0]       hi_o,
  output logic [OUT_W-1:0]       lo_o
);

  localparam int RW = IN_W + 1 - tbml_pkg::FracBits;
  localparam logic signed [RW-1:0] SatHi = RW'((1 << (OUT_W - 1)) - 1);
  localparam logic signed [RW-1:0] SatLo = ~SatHi;
  localparam logic [OUT_W-1:0] OutMax = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OutMin = {1'b1, {(OUT_W-1){1'b0}}};

  logic signed [IN_W:0]    sum;
  logic signed [RW-1:0]    rnd;
  logic signed [OUT_W-1:0] val;
  logic signed [OUT_W-1:0] base_hi, base_lo;
  logic [OUT_W-1:0]        hi_q, hi_d, lo_q, lo_d;

  // Half away from zero: add 8 for positive, 7 for negative, then floor shift
  always_comb begin
    sum = {value_i[IN_W-1], value_i} +
          (value_i[IN_W-1] ? (IN_W+1)'(7) : (IN_W+1)'(8));
    rnd = sum[IN_W:tbml_pkg::FracBits];
    if (rnd > SatHi) begin
      val = $signed(OutMax);
    end else if (rnd < SatLo) begin
      val = $signed(OutMin);
    end else begin
      val = rnd[OUT_W-1:0];
    end
  end

  // Extremes, optionally restarted before the fold
  always_comb begin
    base_hi = ctrl_i.restart ? $signed(OutMin) : $signed(hi_q);
    base_lo = ctrl_i.restart ? $signed(OutMax) : $signed(lo_q);
    hi_d    = (val > base_hi) ? val : base_hi;
    lo_d    = (val < base_lo) ? val : base_lo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_q <= OutMin;
      lo_q <= OutMax;
    end else if (ctrl_i.absorb) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign hi_o = hi_q;
  assign lo_o = lo_q;

endmodule

// ----- rtl/tbml_emit.sv -----
// Result stage: holds a completed record and sends it out one channel per item.
module tbml_emit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  tbml_pkg::rec_t                rec_i,
  output logic                          busy_o,
  output logic                          tvalid_o,
  input  logic                          tready_i,
  output logic [tbml_pkg::OutDataW-1:0] tdata_o,
  output logic [tbml_pkg::ChanW-1:0]    tuser_o,
  output logic                          tlast_o
);

  logic                 valid_q;
  tbml_pkg::channel_e   chan_q, chan_d;
  tbml_pkg::rec_t       rec_q;
  logic                 fire;

  assign fire   = valid_q && tready_i;
  assign chan_d = tbml_pkg::channel_e'(chan_q + tbml_pkg::ChanW'(1));

  // Channel sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      chan_q  <= tbml_pkg::ChPressure;
    end else if (load_i && !valid_q) begin
      valid_q <= 1'b1;
      chan_q  <= tbml_pkg::ChPressure;
    end else if (fire) begin
      if (chan_q == tbml_pkg::ChInHum) begin
        valid_q <= 1'b0;
      end else begin
        chan_q <= chan_d;
      end
    end
  end

  // Record snapshot
  always_ff @(posedge clk_i) begin
    if (load_i && !valid_q) begin
      rec_q <= rec_i;
    end
  end

  // Merge: select the lane picked by the channel counter
  assign tdata_o  = {rec_q.lo[chan_q], rec_q.hi[chan_q], rec_q.bucket,
                     rec_q.day, rec_q.year, rec_q.slot};
  assign tuser_o  = chan_q;
  assign tlast_o  = (chan_q == tbml_pkg::ChInHum);
  assign tvalid_o = valid_q;
  assign busy_o   = valid_q;

endmodule

// ----- rtl/time_bucket_min_max_logger.sv -----
// Time bucket min/max logger: takes timestamped five-channel readings, keeps
// per-bucket extremes in five parallel lanes and emits each completed record
// as five channel items. Each item is accepted, then the radix-2 divider
// forms the bucket number from hour*60+minute and reports done, and then
// the lanes are updated; no new item is accepted before that. An item
// that closes a record also waits until the five results of the previous
// record have all been taken. No clearing pass follows reset; the block is
// ready at once.
module time_bucket_min_max_logger #(
  parameter int SLOTS = tbml_pkg::SlotsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input items
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // tdata: year[7:0], day_of_year[16:8], hour[21:17], minute[27:22],
  // pressure_q4[47:28], outdoor_temp_q4[59:48], indoor_temp_q4[71:60],
  // outdoor_hum_q4[83:72], indoor_hum_q4[95:84]
  input  logic [tbml_pkg::InDataW-1:0]  s_axis_tdata_i,
  // Result items
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // tdata: slot[3:0], rec_year[11:4], rec_day[20:12], rec_bucket[31:21],
  // value_max[47:32], value_min[63:48]
  output logic [tbml_pkg::OutDataW-1:0] m_axis_tdata_o,
  // tuser: channel[2:0]
  output logic [tbml_pkg::ChanW-1:0]    m_axis_tuser_o,
  output logic                          m_axis_tlast_o,
  // Register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tbml_pkg::ApbAddrW-1:0] paddr,
  input  logic [tbml_pkg::ApbDataW-1:0] pwdata,
  output logic [tbml_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);

  localparam int SlotCntW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int BW       = tbml_pkg::BucketW;
  localparam int XW       = tbml_pkg::ValueW - tbml_pkg::ReadOutW;

  // Register file
  logic [BW-1:0] bucket_min_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == tbml_pkg::RegBucketMin) ?
                  tbml_pkg::ApbDataW'(bucket_min_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_min_q <= tbml_pkg::BucketReset;
    end else if (psel && penable && pwrite &&
                 paddr[2] == tbml_pkg::RegBucketMin) begin
      bucket_min_q <= pwdata[BW-1:0];
    end
  end

  // Captured item
  logic [tbml_pkg::YearW-1:0]          year_q;
  logic [tbml_pkg::DayW-1:0]           day_q;
  logic signed [tbml_pkg::PressW-1:0]  press_q;
  logic [tbml_pkg::NumRead-1:0][tbml_pkg::ReadW-1:0] read_q;
  logic                                accept;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      year_q  <= s_axis_tdata_i[7:0];
      day_q   <= s_axis_tdata_i[16:8];
      press_q <= s_axis_tdata_i[47:28];
      read_q  <= s_axis_tdata_i[95:48];
    end
  end

  // Minute of day and bucket length
  logic [BW-1:0] minute_of_day;
  logic [BW-1:0] bucket_len;
  logic          div_done;
  logic [BW-1:0] bucket_num;

  assign minute_of_day = BW'(s_axis_tdata_i[21:17]) * BW'(tbml_pkg::MinPerHour) +
                         BW'(s_axis_tdata_i[27:22]);
  assign bucket_len    = (bucket_min_q == '0) ? BW'(1) : bucket_min_q;

  tbml_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .dividend_i (minute_of_day),
    .divisor_i  (bucket_len),
    .done_o     (div_done),
    .quotient_o (bucket_num)
  );

  // Sequencer state
  tbml_pkg::state_e        state_q, state_d;
  logic                    rec_valid_q;
  logic [tbml_pkg::YearW-1:0] stamp_year_q;
  logic [tbml_pkg::DayW-1:0]  stamp_day_q;
  logic [BW-1:0]           stamp_bucket_q;
  logic [SlotCntW-1:0]     slot_q, slot_d;
  logic                    close;
  logic                    emit_busy;
  logic                    emit_load;
  tbml_pkg::lane_ctrl_t    lane_ctrl;

  assign close = rec_valid_q && (year_q != stamp_year_q || day_q != stamp_day_q ||
                                 bucket_num != stamp_bucket_q);
  assign slot_d = (slot_q == SlotCntW'(SLOTS - 1)) ? '0 : slot_q + SlotCntW'(1);
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  // Next state and controls
  always_comb begin
    state_d           = state_q;
    s_axis_tready_o   = 1'b0;
    emit_load         = 1'b0;
    lane_ctrl.absorb  = 1'b0;
    lane_ctrl.restart = 1'b0;
    unique case (state_q)
      tbml_pkg::StIdle: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          state_d = tbml_pkg::StDiv;
        end
      end
      tbml_pkg::StDiv: begin
        if (div_done) begin
          state_d = tbml_pkg::StDecide;
        end
      end
      tbml_pkg::StDecide: begin
        if (!(close && emit_busy)) begin
          emit_load         = close;
          lane_ctrl.absorb  = 1'b1;
          lane_ctrl.restart = close;
          state_d           = tbml_pkg::StIdle;
        end
      end
      default: state_d = tbml_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tbml_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Open record stamp and slot counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_valid_q    <= 1'b0;
      stamp_year_q   <= '0;
      stamp_day_q    <= '0;
      stamp_bucket_q <= '0;
      slot_q         <= '0;
    end else if (lane_ctrl.absorb) begin
      rec_valid_q    <= 1'b1;
      stamp_year_q   <= year_q;
      stamp_day_q    <= day_q;
      stamp_bucket_q <= bucket_num;
      if (close) begin
        slot_q <= slot_d;
      end
    end
  end

  // Lanes
  logic [tbml_pkg::ValueW-1:0] press_hi, press_lo;
  logic [tbml_pkg::NumRead-1:0][tbml_pkg::ReadOutW-1:0] read_hi, read_lo;

  tbml_lane #(
    .IN_W  (tbml_pkg::PressW),
    .OUT_W (tbml_pkg::ValueW)
  ) u_lane_press (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (lane_ctrl),
    .value_i (press_q),
    .hi_o    (press_hi),
    .lo_o    (press_lo)
  );

  for (genvar g = 0; g < tbml_pkg::NumRead; g++) begin : g_lane
    tbml_lane #(
      .IN_W  (tbml_pkg::ReadW),
      .OUT_W (tbml_pkg::ReadOutW)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (lane_ctrl),
      .value_i ($signed(read_q[g])),
      .hi_o    (read_hi[g]),
      .lo_o    (read_lo[g])
    );
  end

  // Completed record; int8 lanes sign extended
  tbml_pkg::rec_t          rec;
  logic [SlotCntW+3:0]     slot_wide;

  assign slot_wide = {4'b0000, slot_q};

  always_comb begin
    rec.slot   = slot_wide[tbml_pkg::SlotW-1:0];
    rec.year   = stamp_year_q;
    rec.day    = stamp_day_q;
    rec.bucket = stamp_bucket_q;
    rec.hi[0]  = press_hi;
    rec.lo[0]  = press_lo;
    for (int i = 0; i < tbml_pkg::NumRead; i++) begin
      rec.hi[i+1] = {{XW{read_hi[i][tbml_pkg::ReadOutW-1]}}, read_hi[i]};
      rec.lo[i+1] = {{XW{read_lo[i][tbml_pkg::ReadOutW-1]}}, read_lo[i]};
    end
  end

  tbml_emit u_emit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (emit_load),
    .rec_i    (rec),
    .busy_o   (emit_busy),
    .tvalid_o (m_axis_tvalid_o),
    .tready_i (m_axis_tready_i),
    .tdata_o  (m_axis_tdata_o),
    .tuser_o  (m_axis_tuser_o),
    .tlast_o  (m_axis_tlast_o)
  );

  // Checks
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_load |-> !emit_busy)
    else $error("record loaded while result stage busy");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == tbml_pkg::StDiv)
    else $error("divider finished outside the divide state");

  a_close_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_ctrl.restart |=> m_axis_tvalid_o && m_axis_tuser_o == tbml_pkg::ChPressure)
    else $error("closed record does not start with pressure");

  a_open_after_absorb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_ctrl.absorb |=> rec_valid_q)
    else $error("record not open after a reading");

  a_press_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid_q |-> $signed(press_hi) >= $signed(press_lo))
    else $error("pressure maximum below minimum");

endmodule

// ----- tb/tb_top.sv -----
// Testbench for the time bucket min/max logger: directed and random readings with self-checking.
`timescale 1ns / 1ps

module tb_top;
  import tbml_pkg::*;

  localparam int Slots      = SlotsDefault;
  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 400;

  // One input reading, packed in tdata order (lowest field last)
  typedef struct packed {
    logic signed [ReadW-1:0]  hum_in;
    logic signed [ReadW-1:0]  hum_out;
    logic signed [ReadW-1:0]  temp_in;
    logic signed [ReadW-1:0]  temp_out;
    logic signed [PressW-1:0] pressure;
    logic [MinuteW-1:0]       minute;
    logic [HourW-1:0]         hour;
    logic [DayW-1:0]          day;
    logic [YearW-1:0]         year;
  } reading_t;

  // One channel item of a completed record
  typedef struct packed {
    logic [SlotW-1:0]   slot;
    logic [YearW-1:0]   year;
    logic [DayW-1:0]    day;
    logic [BucketW-1:0] bucket;
    channel_e           channel;
    logic [ValueW-1:0]  vmax;
    logic [ValueW-1:0]  vmin;
    logic               last;
  } record_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_valid = 1'b0;
  logic [InDataW-1:0] s_data = '0;
  logic m_ready = 1'b0;
  logic psel_d = 1'b0;
  logic penable_d = 1'b0;
  logic pwrite_d = 1'b0;
  logic [ApbAddrW-1:0] paddr_d = '0;
  logic [ApbDataW-1:0] pwdata_d = '0;

  logic s_ready;
  logic m_valid;
  logic [OutDataW-1:0] m_data;
  logic [ChanW-1:0] m_user;
  logic m_last;
  logic [ApbDataW-1:0] prdata_q;
  logic pready_q;

  always #10 clk_i = ~clk_i;

  time_bucket_min_max_logger #(.SLOTS(Slots)) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_user),
    .m_axis_tlast_o (m_last),
    .psel           (psel_d),
    .penable        (penable_d),
    .pwrite         (pwrite_d),
    .paddr          (paddr_d),
    .pwdata         (pwdata_d),
    .prdata         (prdata_q),
    .pready         (pready_q)
  );

  // Predictor state
  int  bucket_len = 180;
  bit  rec_open;
  int  st_year, st_day, st_bucket;
  int  press_hi, press_lo;
  int  read_hi[NumRead];
  int  read_lo[NumRead];
  int  slot_count;

  record_item_t pending_records[$];

  // Run control and bookkeeping
  bit  sender_gaps = 1'b1;
  bit  receiver_stalls = 1'b1;
  int  hold_count, hold_seen, hold_left;
  int  fail_count;
  int  items_sent, results_seen, records_done, cfg_writes;
  int  cycle_count;

  // Random stimulus cursor: stamp of the record being built
  int  cur_year, cur_day, cur_min;

  function automatic int round_sat(int x, int lo, int hi);
    int r;
    if (x >= 0) r = (x + 8) >>> FracBits;
    else r = -((-x + 8) >>> FracBits);
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return r;
  endfunction

  task automatic restart_extremes();
    press_hi = -32768;
    press_lo = 32767;
    for (int i = 0; i < NumRead; i++) begin
      read_hi[i] = -128;
      read_lo[i] = 127;
    end
  endtask

  // Fold one accepted reading into the predicted state; queue any closed record
  task automatic log_reading(input reading_t r);
    int len, bkt, p, hi, lo;
    int v[NumRead];
    record_item_t rec;
    len = (bucket_len == 0) ? 1 : bucket_len;
    bkt = ((int'(r.hour) * MinPerHour + int'(r.minute)) / len) & 'h7FF;
    p = round_sat(int'(r.pressure), -32768, 32767);
    v[0] = round_sat(int'(r.temp_out), -128, 127);
    v[1] = round_sat(int'(r.temp_in), -128, 127);
    v[2] = round_sat(int'(r.hum_out), -128, 127);
    v[3] = round_sat(int'(r.hum_in), -128, 127);
    if (rec_open && (int'(r.year) != st_year || int'(r.day) != st_day || bkt != st_bucket)) begin
      for (int ch = 0; ch < NumCh; ch++) begin
        hi = (ch == 0) ? press_hi : read_hi[ch-1];
        lo = (ch == 0) ? press_lo : read_lo[ch-1];
        rec.slot    = SlotW'(slot_count);
        rec.year    = YearW'(st_year);
        rec.day     = DayW'(st_day);
        rec.bucket  = BucketW'(st_bucket);
        rec.channel = channel_e'(ch);
        rec.vmax    = ValueW'(hi);
        rec.vmin    = ValueW'(lo);
        rec.last    = (ch == NumCh - 1);
        pending_records.push_back(rec);
      end
      slot_count = (slot_count + 1) % Slots;
      records_done++;
      restart_extremes();
    end
    rec_open  = 1'b1;
    st_year   = r.year;
    st_day    = r.day;
    st_bucket = bkt;
    if (p > press_hi) press_hi = p;
    if (p < press_lo) press_lo = p;
    for (int i = 0; i < NumRead; i++) begin
      if (v[i] > read_hi[i]) read_hi[i] = v[i];
      if (v[i] < read_lo[i]) read_lo[i] = v[i];
    end
  endtask

  // Offer one item; valid stays high after acceptance until the next item or an idle
  task automatic send_reading(input reading_t r);
    if (sender_gaps && $urandom_range(99) < 19) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= r;
    do @(posedge clk_i); while (!s_ready);
    log_reading(r);
    items_sent++;
  endtask

  task automatic input_idle();
    s_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    input_idle();
    while (pending_records.size() != 0) @(posedge clk_i);
  endtask

  // Idle point for register access: results drained and any absorb finished
  task automatic settle();
    wait_drained();
    repeat (40) @(posedge clk_i);
  endtask

  // Register write followed by a read back
  task automatic write_bucket_len(input int val);
    psel_d    <= 1'b1;
    penable_d <= 1'b0;
    pwrite_d  <= 1'b1;
    paddr_d   <= {RegBucketMin, 2'b00};
    pwdata_d  <= ApbDataW'(val);
    @(posedge clk_i);
    penable_d <= 1'b1;
    @(posedge clk_i);
    bucket_len = val & 'h7FF;
    cfg_writes++;
    penable_d <= 1'b0;
    pwrite_d  <= 1'b0;
    @(posedge clk_i);
    penable_d <= 1'b1;
    @(posedge clk_i);
    if (prdata_q !== ApbDataW'(bucket_len)) begin
      fail_count++;
      $display("%0t: bucket_minutes read back exp %0d got %0d", $time, bucket_len, prdata_q);
    end
    psel_d    <= 1'b0;
    penable_d <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic reading_t make_reading(int y, int d, int h, int m, int p, int a, int b);
    reading_t r;
    r.year     = YearW'(y);
    r.day      = DayW'(d);
    r.hour     = HourW'(h);
    r.minute   = MinuteW'(m);
    r.pressure = PressW'(p);
    r.temp_out = ReadW'(a);
    r.temp_in  = ReadW'(b);
    r.hum_out  = ReadW'(a);
    r.hum_in   = ReadW'(b);
    return r;
  endfunction

  // Random value of a signed field: mostly uniform, with extremes and rounding edges
  function automatic int rand_q4(int w);
    int lo, hi;
    lo = -(1 << (w - 1));
    hi = (1 << (w - 1)) - 1;
    case ($urandom_range(9))
      0: return lo;
      1: return hi;
      2: return $urandom_range(48) - 24;
      default: return $urandom_range(hi - lo) + lo;
    endcase
  endfunction

  // Mostly well-formed stamps that stay in or step out of the open bucket
  function automatic reading_t rand_reading();
    reading_t r;
    int pick, step;
    pick = $urandom_range(99);
    step = (bucket_len > 200) ? 200 : bucket_len + 1;
    if (pick < 45) begin
      // same bucket stamp
    end else if (pick < 75) begin
      cur_min = (cur_min + $urandom_range(0, step)) % 1440;
    end else if (pick < 85) begin
      cur_day = (cur_day + 1) % 366;
    end else if (pick < 90) begin
      cur_year = (cur_year + 1) % 256;
    end
    r.year     = YearW'(cur_year);
    r.day      = DayW'(cur_day);
    r.hour     = HourW'(cur_min / 60);
    r.minute   = MinuteW'(cur_min % 60);
    if (pick >= 90) begin
      // noise: any stamp the fields allow
      r.year   = YearW'($urandom);
      r.day    = DayW'($urandom);
      r.hour   = HourW'($urandom);
      r.minute = MinuteW'($urandom);
    end
    r.pressure = PressW'(rand_q4(PressW));
    r.temp_out = ReadW'(rand_q4(ReadW));
    r.temp_in  = ReadW'(rand_q4(ReadW));
    r.hum_out  = ReadW'(rand_q4(ReadW));
    r.hum_in   = ReadW'(rand_q4(ReadW));
    return r;
  endfunction

  // Opening reading emits nothing; then full-scale values saturate
  task automatic test_open_and_saturation();
    send_reading(make_reading(0, 0, 0, 0, 0, 0, 0));
    send_reading(make_reading(0, 0, 0, 5, 524287, 2047, -2048));
    send_reading(make_reading(0, 0, 1, 0, -524288, -2048, 2047));
    send_reading(make_reading(0, 0, 2, 59, 100, 5, -5));
    settle();
  endtask

  // One reading per bucket so every rounded value shows up in a record
  task automatic test_rounding();
    int vals[12] = '{8, 7, -8, -7, 24, -24, 9, -9, 23, -23, 2039, -2040};
    for (int i = 0; i < 6; i++)
      send_reading(make_reading(0, 0, 3 + 3 * i, 0, vals[2*i] * 16 + vals[2*i+1],
                                vals[2*i], vals[2*i+1]));
    settle();
  endtask

  // Day and year changes at the same time of day, then time fields out of range
  task automatic test_stamp_changes();
    send_reading(make_reading(0, 1, 18, 0, -1000, 100, -100));
    send_reading(make_reading(1, 1, 18, 0, 1000, -100, 100));
    send_reading(make_reading(255, 365, 18, 0, 7, 0, 0));
    send_reading(make_reading(255, 511, 31, 63, -7, 1, -1));
    settle();
  endtask

  // Zero, oversize and boundary lengths, with length changes on an open record
  task automatic test_lengths();
    write_bucket_len(0);
    send_reading(make_reading(3, 10, 0, 10, 10, 10, 10));
    send_reading(make_reading(3, 10, 0, 11, 11, 11, 11));
    settle();
    write_bucket_len(2047);
    send_reading(make_reading(3, 10, 0, 0, 20, 20, 20));
    send_reading(make_reading(3, 10, 23, 59, 21, 21, 21));
    send_reading(make_reading(3, 10, 31, 63, 22, 22, 22));
    settle();
    write_bucket_len(1);
    send_reading(make_reading(3, 10, 0, 30, 30, 30, 30));
    settle();
    write_bucket_len(1440);
    send_reading(make_reading(3, 10, 0, 30, 31, 31, 31));
    send_reading(make_reading(3, 10, 23, 59, 32, 32, 32));
    settle();
  endtask

  // Random readings over several bucket lengths, one phase with no idling
  task automatic test_random();
    int lens[6] = '{7, 60, 1, 180, 1440, 15};
    for (int ph = 0; ph < 6; ph++) begin
      write_bucket_len(lens[ph]);
      sender_gaps     = (ph != 2);
      receiver_stalls = (ph != 2);
      for (int i = 0; i < 35; i++) send_reading(rand_reading());
      settle();
    end
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  // Receiver holds off while every reading closes a record, so the input stalls
  task automatic test_backpressure();
    reading_t r;
    write_bucket_len(1);
    hold_count++;
    for (int i = 0; i < 20; i++) begin
      cur_min = (cur_min + 1) % 1440;
      r = rand_reading();
      r.year   = YearW'(cur_year);
      r.day    = DayW'(cur_day);
      r.hour   = HourW'(cur_min / 60);
      r.minute = MinuteW'(cur_min % 60);
      send_reading(r);
    end
    settle();
  endtask

  // Sender pauses until all results are in, then resumes
  task automatic test_drain_pause();
    write_bucket_len(30);
    for (int i = 0; i < 5; i++) send_reading(rand_reading());
    wait_drained();
    for (int i = 0; i < 5; i++) send_reading(rand_reading());
    settle();
  endtask

  // Receiver ready: random stalls, plus a counted hold-off on request
  always @(posedge clk_i) begin
    if (hold_count != hold_seen) begin
      hold_seen = hold_count;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_ready <= 1'b0;
    end else if (receiver_stalls) begin
      m_ready <= ($urandom_range(99) >= 19);
    end else begin
      m_ready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest queued record item
  always @(posedge clk_i) begin
    record_item_t got, want;
    if (rst_ni && m_valid && m_ready) begin
      got.slot    = m_data[3:0];
      got.year    = m_data[11:4];
      got.day     = m_data[20:12];
      got.bucket  = m_data[31:21];
      got.vmax    = m_data[47:32];
      got.vmin    = m_data[63:48];
      got.channel = channel_e'(m_user);
      got.last    = m_last;
      results_seen++;
      if (pending_records.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result exp none got %p", $time, got);
      end else begin
        want = pending_records.pop_front();
        if (got.slot !== want.slot || got.year !== want.year || got.day !== want.day ||
            got.bucket !== want.bucket || got.channel !== want.channel ||
            got.vmax !== want.vmax || got.vmin !== want.vmin || got.last !== want.last) begin
          fail_count++;
          $display("%0t: result mismatch exp %p got %p", $time, want, got);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout with %0d results pending", $time, pending_records.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    restart_extremes();
    cur_year = 120;
    cur_day  = 40;
    cur_min  = 300;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_open_and_saturation();
    test_rounding();
    test_stamp_changes();
    test_lengths();
    test_random();
    test_backpressure();
    test_drain_pause();

    settle();
    if (pending_records.size() != 0) begin
      fail_count++;
      $display("%0t: %0d expected results never arrived", $time, pending_records.size());
    end
    $display("Ran %0d readings, %0d records, %0d results, %0d register writes;",
             items_sent, records_done, results_seen, cfg_writes);
    $display("covered saturation, rounding, stamp changes, odd lengths and back-pressure.");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- time_bucket_min_max_logger.f -----
rtl/tbml_pkg.sv
rtl/tbml_div.sv
rtl/tbml_lane.sv
rtl/tbml_emit.sv
rtl/time_bucket_min_max_logger.sv
tb/tb_top.sv
